>>> rtl/tlb_page_table_translator_macros.svh
// Assertion macros shared by the translator modules.
`ifndef TLB_PAGE_TABLE_TRANSLATOR_MACROS_SVH
`define TLB_PAGE_TABLE_TRANSLATOR_MACROS_SVH
// Implication checked on every rising edge outside reset.
`define TPT_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication checked on every rising edge outside reset.
`define TPT_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`endif

>>> rtl/tpt_pkg.sv
// Package with types and constants of the address translator.
`timescale 1ns / 1ps
package tpt_pkg;
  localparam int unsigned PageBytesDef  = 1024;
  localparam int unsigned TlbEntriesDef = 8;
  localparam int unsigned FrameCountDef = 16;
  localparam int unsigned PageCountDef  = 64;
  localparam int unsigned VaWidth       = 16;
  localparam int unsigned TimeWidth     = 32;
  localparam int unsigned PaWidth       = 14;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_TABLE,
    ST_ALLOC,
    ST_OUT
  } state_e;
endpackage

>>> rtl/tpt_tlb_cell.sv
// One TLB slot that matches a page and passes a running lookup and victim choice on.
`timescale 1ns / 1ps
`include "tlb_page_table_translator_macros.svh"
module tpt_tlb_cell import tpt_pkg::*; #(
  parameter int unsigned PageW  = 6,
  parameter int unsigned FrameW = 4,
  parameter int unsigned IdxW   = 3,
  parameter int unsigned MyIdx  = 0
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic [PageW-1:0]     page_i,
  input  logic                 hit_i,
  input  logic [FrameW-1:0]    hit_frame_i,
  input  logic                 free_i,
  input  logic [IdxW-1:0]      vic_i,
  input  logic [TimeWidth-1:0] vic_time_i,
  output logic                 hit_o,
  output logic [FrameW-1:0]    hit_frame_o,
  output logic                 free_o,
  output logic [IdxW-1:0]      vic_o,
  output logic [TimeWidth-1:0] vic_time_o,
  input  logic                 wr_i,
  input  logic [IdxW-1:0]      wr_idx_i,
  input  logic [FrameW-1:0]    wr_frame_i,
  input  logic [TimeWidth-1:0] wr_time_i
);
  logic                 valid_q;
  logic [PageW-1:0]     page_q;
  logic [FrameW-1:0]    frame_q;
  logic [TimeWidth-1:0] created_q;
  logic                 match;

  assign match = valid_q && (page_q == page_i);

  always_comb begin
    hit_o       = hit_i;
    hit_frame_o = hit_frame_i;
    free_o      = free_i;
    vic_o       = vic_i;
    vic_time_o  = vic_time_i;
    if (!hit_i && match) begin
      hit_o       = 1'b1;
      hit_frame_o = frame_q;
    end
    if (!free_i) begin
      if (!valid_q) begin
        free_o = 1'b1;
        vic_o  = IdxW'(MyIdx);
      end else if (MyIdx == 0 || created_q < vic_time_i) begin
        vic_o      = IdxW'(MyIdx);
        vic_time_o = created_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q   <= 1'b0;
      created_q <= '0;
    end else if (wr_i && wr_idx_i == IdxW'(MyIdx)) begin
      valid_q   <= 1'b1;
      created_q <= wr_time_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_i && wr_idx_i == IdxW'(MyIdx)) begin
      page_q  <= page_i;
      frame_q <= wr_frame_i;
    end
  end

  `TPT_ASSERT_NXT(a_wr_valid, clk_i, rst_ni, wr_i && wr_idx_i == IdxW'(MyIdx), valid_q, "slot not valid after write")
  `TPT_ASSERT_IMP(a_free_invalid, clk_i, rst_ni, free_o && !free_i, !valid_q, "free slot claimed by valid entry")
  `TPT_ASSERT_IMP(a_hit_keep, clk_i, rst_ni, hit_i, hit_o && hit_frame_o == hit_frame_i, "earlier hit overridden")
endmodule

>>> rtl/tlb_page_table_translator.sv
// On a TLB hit the input beat goes through the TLB lookup to the result register;
// on a miss through TLB lookup, page table read, frame allocation and result register.
// A new beat is taken only after the result beat has been taken, since ready_o is high
// only in idle; an output stall therefore also holds off the next input beat.
// Reset clears all TLB, page table and frame valid bits at once; no clearing pass.
// Page table frame numbers are held in a memory with a registered read.
`timescale 1ns / 1ps
`include "tlb_page_table_translator_macros.svh"
module tlb_page_table_translator import tpt_pkg::*; #(
  parameter int unsigned PAGE_BYTES  = PageBytesDef,
  parameter int unsigned TLB_ENTRIES = TlbEntriesDef,
  parameter int unsigned FRAME_COUNT = FrameCountDef,
  parameter int unsigned PAGE_COUNT  = PageCountDef
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 valid_i,
  output logic                 ready_o,
  input  logic [VaWidth-1:0]   virtual_address_i,
  input  logic [TimeWidth-1:0] request_time_i,
  output logic                 valid_o,
  input  logic                 ready_i,
  output logic [PaWidth-1:0]   physical_address_o,
  output logic                 tlb_hit_o,
  output logic                 table_hit_o,
  output logic                 frame_allocated_o,
  output logic                 memory_full_o
);
  localparam int unsigned OffW   = $clog2(PAGE_BYTES);
  localparam int unsigned PageW  = (PAGE_COUNT > 1) ? $clog2(PAGE_COUNT) : 1;
  localparam int unsigned FrameW = (FRAME_COUNT > 1) ? $clog2(FRAME_COUNT) : 1;
  localparam int unsigned IdxW   = (TLB_ENTRIES > 1) ? $clog2(TLB_ENTRIES) : 1;
  localparam int unsigned PaFull = FrameW + OffW;

  state_e state_q, state_d;

  logic [VaWidth-1:0]   va_q;
  logic [TimeWidth-1:0] time_q;
  logic [PageW-1:0]     page;
  logic [OffW-1:0]      offset;
  logic [FrameW-1:0]    frame_d;
  logic [PageW-1:0]     page_q;

  logic [TLB_ENTRIES:0]               c_hit, c_free;
  logic [TLB_ENTRIES:0][FrameW-1:0]   c_frame;
  logic [TLB_ENTRIES:0][IdxW-1:0]     c_vic;
  logic [TLB_ENTRIES:0][TimeWidth-1:0] c_vtime;
  logic [IdxW-1:0]                    vic_q;

  logic [PAGE_COUNT-1:0]  tvalid_q;
  logic [FrameW-1:0]      tmem [PAGE_COUNT];
  logic [FrameW-1:0]      trd_q;
  logic [FRAME_COUNT-1:0] used_q;
  logic                   free_found;
  logic [FrameW-1:0]      free_idx;

  logic tlb_wr;
  logic ohit_q, othit_q, oalloc_q, ofull_q;
  logic [PaWidth-1:0] opa_q;
  logic [PaFull-1:0] pa_full;

  assign offset = va_q[OffW-1:0];
  if (VaWidth > OffW) begin : g_page
    logic [VaWidth-OffW-1:0] pn;
    assign pn   = va_q[VaWidth-1:OffW];
    assign page = PageW'(pn % PAGE_COUNT);
  end else begin : g_page0
    assign page = '0;
  end

  assign c_hit[0]   = 1'b0;
  assign c_frame[0] = '0;
  assign c_free[0]  = 1'b0;
  assign c_vic[0]   = '0;
  assign c_vtime[0] = '0;

  for (genvar k = 0; k < TLB_ENTRIES; k++) begin : g_cell
    tpt_tlb_cell #(.PageW(PageW), .FrameW(FrameW), .IdxW(IdxW), .MyIdx(k)) u_cell (
      .clk_i, .rst_ni,
      .page_i      (page),
      .hit_i       (c_hit[k]),   .hit_frame_i(c_frame[k]),
      .free_i      (c_free[k]),  .vic_i(c_vic[k]), .vic_time_i(c_vtime[k]),
      .hit_o       (c_hit[k+1]), .hit_frame_o(c_frame[k+1]),
      .free_o      (c_free[k+1]), .vic_o(c_vic[k+1]), .vic_time_o(c_vtime[k+1]),
      .wr_i        (tlb_wr),     .wr_idx_i(vic_q),
      .wr_frame_i  (frame_d),    .wr_time_i(time_q)
    );
  end

  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int f = FRAME_COUNT - 1; f >= 0; f--) begin
      if (!used_q[f]) begin
        free_found = 1'b1;
        free_idx   = FrameW'(f);
      end
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:  if (valid_i) state_d = ST_SCAN;
      ST_SCAN:  state_d = c_hit[TLB_ENTRIES] ? ST_OUT : ST_TABLE;
      ST_TABLE: state_d = ST_ALLOC;
      ST_ALLOC: state_d = ST_OUT;
      ST_OUT:   if (ready_i) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    ready_o = (state_q == ST_IDLE);
    valid_o = (state_q == ST_OUT);
    tlb_wr  = 1'b0;
    frame_d = trd_q;
    if (state_q == ST_ALLOC) begin
      if (tvalid_q[page_q]) begin
        frame_d = trd_q;
        tlb_wr  = 1'b1;
      end else begin
        frame_d = free_idx;
        tlb_wr  = free_found;
      end
    end
  end

  assign pa_full = {frame_d, offset};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      tvalid_q <= '0;
      used_q   <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_ALLOC && !tvalid_q[page_q] && free_found) begin
        tvalid_q[page_q]  <= 1'b1;
        used_q[free_idx]  <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && valid_i) begin
      va_q   <= virtual_address_i;
      time_q <= request_time_i;
    end
    if (state_q == ST_SCAN) begin
      vic_q <= c_vic[TLB_ENTRIES];
      page_q <= page;
    end
    trd_q <= tmem[page];
    if (state_q == ST_ALLOC && !tvalid_q[page_q] && free_found) tmem[page_q] <= free_idx;
    if (state_q == ST_SCAN && c_hit[TLB_ENTRIES]) begin
      opa_q    <= PaWidth'({c_frame[TLB_ENTRIES], offset});
      ohit_q   <= 1'b1;
      othit_q  <= 1'b0;
      oalloc_q <= 1'b0;
      ofull_q  <= 1'b0;
    end
    if (state_q == ST_ALLOC) begin
      ohit_q   <= 1'b0;
      othit_q  <= tvalid_q[page_q];
      oalloc_q <= !tvalid_q[page_q] && free_found;
      ofull_q  <= !tvalid_q[page_q] && !free_found;
      opa_q    <= (tvalid_q[page_q] || free_found) ? PaWidth'(pa_full) : '0;
    end
  end

  assign physical_address_o = opa_q;
  assign tlb_hit_o          = ohit_q;
  assign table_hit_o        = othit_q;
  assign frame_allocated_o  = oalloc_q;
  assign memory_full_o      = ofull_q;

  `TPT_ASSERT_IMP(a_onehot_flags, clk_i, rst_ni, valid_o, $onehot({tlb_hit_o, table_hit_o, frame_allocated_o, memory_full_o}), "result flags not one-hot")
  `TPT_ASSERT_IMP(a_full_zero, clk_i, rst_ni, valid_o && memory_full_o, physical_address_o == '0, "full result has nonzero address")
  `TPT_ASSERT_NXT(a_alloc_marks, clk_i, rst_ni, state_q == ST_ALLOC && !tvalid_q[page_q] && free_found, tvalid_q[$past(page_q)], "page not marked valid")
endmodule
